// ===== hw/rtl/eqr_pkg.sv =====
// Shared types and constants for the event queue with retransmit.
package eqr_pkg;

  localparam int unsigned EQR_DEPTH = 8;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SEQ_W = 16;
  localparam int unsigned CTR_W = 16;
  localparam int unsigned SENDS_W = 4;
  localparam int unsigned PEND_W = 4;
  localparam int unsigned MS_W = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_WINDOW = 2'd2;

  localparam logic [MS_W-1:0] RETRY_GAP_RST = 16'd200;
  localparam logic [SENDS_W-1:0] SEND_LIMIT_RST = 4'd3;
  localparam logic [MS_W-1:0] HOST_WINDOW_RST = 16'd3000;

  localparam logic MODE_NOTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] event_code;
    logic [WORD_W-1:0] event_detail;
    logic [WORD_W-1:0] now_ms;
    logic [WORD_W-1:0] host_last_ms;
    logic              link_space;
  } item_t;

  typedef struct packed {
    logic              sent;
    logic [CODE_W-1:0] out_code;
    logic [WORD_W-1:0] out_detail;
    logic [SEQ_W-1:0]  out_seq;
    logic [CTR_W-1:0]  total_low;
    logic [CTR_W-1:0]  dropped_count;
    logic [PEND_W-1:0] pending;
    logic              idle;
  } result_t;

  typedef struct packed {
    logic [MS_W-1:0]    retry_gap_ms;
    logic [SENDS_W-1:0] send_limit;
    logic [MS_W-1:0]    host_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] detail;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

endpackage

// ===== hw/rtl/eqr_ring.sv =====
// Ring buffer state, entry memory and the per-item update logic.
module eqr_ring
  import eqr_pkg::*;
#(
  parameter int unsigned DEPTH = EQR_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // Only code, detail and sequence number live in the memory. Send count and
  // last send time matter for the head entry alone, so they are registers.
  entry_t mem [DEPTH];
  entry_t head_entry_r;

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [CTR_W-1:0]   total_r, total_nxt;
  logic [CTR_W-1:0]   drop_r, drop_nxt;
  logic [SENDS_W-1:0] sends_r, sends_nxt;
  logic [WORD_W-1:0]  last_r, last_nxt;

  logic               full;
  logic [IDX_W-1:0]   head_inc;
  logic [SUM_W-1:0]   slot_sum;
  logic [IDX_W-1:0]   slot;
  logic               wr_en;
  entry_t             wr_entry;
  logic [WORD_W-1:0]  seen_age;
  logic [WORD_W-1:0]  send_age;
  logic               can_send;
  logic [SENDS_W-1:0] sends_inc;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);

  // When full, the oldest entry is dropped and its slot takes the new one.
  always_comb begin
    slot_sum = SUM_W'(head_r) + SUM_W'(fill_r);
    if (slot_sum >= SUM_W'(DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(DEPTH);
    end
    slot = full ? head_r : slot_sum[IDX_W-1:0];
  end

  assign seen_age  = item.now_ms - item.host_last_ms;
  assign send_age  = item.now_ms - last_r;
  assign sends_inc = sends_r + SENDS_W'(1);

  assign can_send = (fill_r != '0) && (item.host_last_ms != '0)
                    && (seen_age < WORD_W'(cfg.host_window_ms)) && item.link_space
                    && ((sends_r == '0) || (send_age >= WORD_W'(cfg.retry_gap_ms)));

  assign wr_en           = item_valid && (item.mode == MODE_NOTE) && (item.event_code != '0);
  assign wr_entry.code   = item.event_code;
  assign wr_entry.detail = item.event_detail;
  assign wr_entry.seq    = seq_r + SEQ_W'(1);

  always_comb begin
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    seq_nxt   = seq_r;
    total_nxt = total_r;
    drop_nxt  = drop_r;
    sends_nxt = sends_r;
    last_nxt  = last_r;
    result    = '0;
    if (wr_en) begin
      seq_nxt   = wr_entry.seq;
      total_nxt = total_r + CTR_W'(1);
      if (full) begin
        head_nxt  = head_inc;
        drop_nxt  = drop_r + CTR_W'(1);
        sends_nxt = '0;
        last_nxt  = '0;
      end else begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end else if (item_valid && (item.mode == MODE_TICK) && can_send) begin
      result.sent       = 1'b1;
      result.out_code   = head_entry_r.code;
      result.out_detail = head_entry_r.detail;
      result.out_seq    = head_entry_r.seq;
      if (sends_inc >= cfg.send_limit) begin
        head_nxt  = head_inc;
        fill_nxt  = fill_r - CNT_W'(1);
        sends_nxt = '0;
        last_nxt  = '0;
      end else begin
        sends_nxt = sends_inc;
        last_nxt  = item.now_ms;
      end
    end
    result.total_low     = total_nxt;
    result.dropped_count = drop_nxt;
    result.pending       = PEND_W'(fill_nxt);
    result.idle          = (fill_nxt == '0);
  end

  // The read port follows the next head, with the write forwarded when a new
  // entry lands in the head slot of an empty queue.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_entry;
    end
    if (wr_en && (slot == head_nxt)) begin
      head_entry_r <= wr_entry;
    end else begin
      head_entry_r <= mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      seq_r   <= '0;
      total_r <= '0;
      drop_r  <= '0;
      sends_r <= '0;
      last_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      seq_r   <= seq_nxt;
      total_r <= total_nxt;
      drop_r  <= drop_nxt;
      sends_r <= sends_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ===== hw/rtl/event_queue_retransmit.sv =====
// Event log queue with repeated sending of the oldest entry: top level.
//
// A note item (mode 0, nonzero code) appends an event, dropping the oldest
// one when the queue is full; a tick item (mode 1) sends the head event when
// the host is online, the link has space and the resend gap has passed. The
// block takes one item every cycle: busy is high during reset, drops at the
// first clock edge after rst_n rises and stays low from then on. Each item
// yields exactly one result, shown on out_valid for a single cycle. The item
// passes through the input register and then through the queue update logic
// into the result register. The receiver cannot hold results off and must
// take each one in the cycle it appears.
module event_queue_retransmit
  import eqr_pkg::*;
#(
  parameter int unsigned DEPTH = EQR_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 in_item,
  output logic                  out_valid,
  output result_t               out_result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic    busy_r;
  logic    item_valid_r;
  item_t   item_r;
  cfg_t    cfg_r;
  result_t ring_result;
  logic    out_valid_r;
  result_t out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      item_valid_r <= start && !busy_r;
      out_valid_r  <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= in_item;
    out_result_r <= ring_result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_gap_ms   <= RETRY_GAP_RST;
      cfg_r.send_limit     <= SEND_LIMIT_RST;
      cfg_r.host_window_ms <= HOST_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RETRY_GAP:   cfg_r.retry_gap_ms   <= cfg_wdata[MS_W-1:0];
        REG_SEND_LIMIT:  cfg_r.send_limit     <= cfg_wdata[SENDS_W-1:0];
        REG_HOST_WINDOW: cfg_r.host_window_ms <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  eqr_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid_r),
    .item      (item_r),
    .cfg       (cfg_r),
    .result    (ring_result)
  );

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ===== hw/rtl/eqr_checker.sv =====
// Port-level checker for the event queue top level, with its bind.
module eqr_checker
  import eqr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input item_t                 in_item,
  input logic                  out_valid,
  input result_t               out_result
);

  // Every taken item is followed by its result on out_valid.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("taken item produced no result");

  // No result appears without a matching item taken before it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a taken item");

  // A note item only records; it never sends an event.
  a_note_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.mode == MODE_NOTE)) |-> ##2 !out_result.sent)
    else $error("note item produced a send");

  // Stored events always carry a nonzero code.
  a_sent_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.sent) |-> (out_result.out_code != '0))
    else $error("sent event with zero code");

  a_unsent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.sent) |->
      (out_result.out_code == '0 && out_result.out_detail == '0
       && out_result.out_seq == '0))
    else $error("event fields set on a result that sent nothing");

endmodule

bind event_queue_retransmit eqr_checker u_eqr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_result(out_result)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the event queue with retransmit of the oldest entry.
module tb_top;
  import eqr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = EQR_DEPTH;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  item_t                 in_item = '0;
  logic                  out_valid;
  result_t               out_result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_RETRY_GAP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  event_queue_retransmit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow copy of the event log, updated as each item is taken.
  logic [CODE_W-1:0]  log_code      [DEPTH];
  logic [WORD_W-1:0]  log_detail    [DEPTH];
  logic [SEQ_W-1:0]   log_seq       [DEPTH];
  logic [SENDS_W-1:0] log_sends     [DEPTH];
  logic [WORD_W-1:0]  log_last_send [DEPTH];
  int unsigned        log_head = 0;
  int unsigned        log_fill = 0;
  logic [SEQ_W-1:0]   seq_ctr = '0;
  logic [CTR_W-1:0]   total_ctr = '0;
  logic [CTR_W-1:0]   drop_ctr = '0;
  cfg_t cfg_model = '{retry_gap_ms: RETRY_GAP_RST, send_limit: SEND_LIMIT_RST,
                      host_window_ms: HOST_WINDOW_RST};

  item_t       pending_items [$];
  result_t     due_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_taken = 0;
  int unsigned events_sent = 0;
  int unsigned overflow_drops = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_no = 0;
  logic [WORD_W-1:0] clock_ms = 32'h0000_1000;

  function automatic result_t advance_log(item_t it);
    result_t r;
    logic [IDX_W-1:0] slot;
    logic [WORD_W-1:0] age;
    r = '0;
    if (it.mode == MODE_NOTE) begin
      if (it.event_code != '0) begin
        if (log_fill >= DEPTH) begin
          log_head = (log_head + 1) % DEPTH;
          log_fill--;
          drop_ctr = drop_ctr + CTR_W'(1);
          overflow_drops++;
        end
        slot = IDX_W'((log_head + log_fill) % DEPTH);
        seq_ctr = seq_ctr + SEQ_W'(1);
        log_code[slot] = it.event_code;
        log_detail[slot] = it.event_detail;
        log_seq[slot] = seq_ctr;
        log_sends[slot] = '0;
        log_last_send[slot] = '0;
        log_fill++;
        total_ctr = total_ctr + CTR_W'(1);
      end
    end else begin
      age = it.now_ms - it.host_last_ms;
      if (log_fill != 0 && it.host_last_ms != '0 && age < WORD_W'(cfg_model.host_window_ms)
          && it.link_space) begin
        slot = IDX_W'(log_head);
        age = it.now_ms - log_last_send[slot];
        if (log_sends[slot] == '0 || age >= WORD_W'(cfg_model.retry_gap_ms)) begin
          r.sent = 1'b1;
          r.out_code = log_code[slot];
          r.out_detail = log_detail[slot];
          r.out_seq = log_seq[slot];
          log_sends[slot] = log_sends[slot] + SENDS_W'(1);
          log_last_send[slot] = it.now_ms;
          if (log_sends[slot] >= cfg_model.send_limit) begin
            log_head = (log_head + 1) % DEPTH;
            log_fill--;
          end
          events_sent++;
        end
      end
    end
    r.total_low = total_ctr;
    r.dropped_count = drop_ctr;
    r.pending = PEND_W'(log_fill);
    r.idle = (log_fill == 0);
    return r;
  endfunction

  // Driver: presents queued items, with random gaps outside the calm stretches.
  always @(posedge clk) begin
    cycle_no++;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_results.push_back(advance_log(in_item));
        items_taken++;
      end
      if (!(start && busy)) begin
        if (pending_items.size() != 0 &&
            ((cycle_no % 3000) < 700 || $urandom_range(0, 99) >= 10)) begin
          in_item <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d, %s: expected %h, got %h", results_seen, what, want, got);
    end
  endtask

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with no item waiting", results_seen);
      end else begin
        want = due_results.pop_front();
        check_field("sent", WORD_W'(want.sent), WORD_W'(out_result.sent));
        check_field("out_code", WORD_W'(want.out_code), WORD_W'(out_result.out_code));
        check_field("out_detail", want.out_detail, out_result.out_detail);
        check_field("out_seq", WORD_W'(want.out_seq), WORD_W'(out_result.out_seq));
        check_field("total_low", WORD_W'(want.total_low), WORD_W'(out_result.total_low));
        check_field("dropped_count", WORD_W'(want.dropped_count),
                    WORD_W'(out_result.dropped_count));
        check_field("pending", WORD_W'(want.pending), WORD_W'(out_result.pending));
        check_field("idle", WORD_W'(want.idle), WORD_W'(out_result.idle));
      end
      results_seen++;
    end
  end

  task automatic queue_note(logic [CODE_W-1:0] code, logic [WORD_W-1:0] detail);
    item_t it;
    it.mode = MODE_NOTE;
    it.event_code = code;
    it.event_detail = detail;
    it.now_ms = $urandom;
    it.host_last_ms = $urandom;
    it.link_space = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
  endtask

  task automatic queue_tick(logic [WORD_W-1:0] now, logic [WORD_W-1:0] seen, logic space);
    item_t it;
    it.mode = MODE_TICK;
    it.event_code = CODE_W'($urandom);
    it.event_detail = $urandom;
    it.now_ms = now;
    it.host_last_ms = seen;
    it.link_space = space;
    pending_items.push_back(it);
  endtask

  // Mostly a plausible timeline with the host online; the rest is noise.
  task automatic queue_random_item();
    int unsigned pick;
    int unsigned win;
    logic [WORD_W-1:0] seen;
    pick = $urandom_range(0, 99);
    win = 32'(cfg_model.host_window_ms);
    if (pick < 45) begin
      queue_note(($urandom_range(0, 19) == 0) ? '0 : CODE_W'($urandom_range(1, 255)), $urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) clock_ms += $urandom_range(0, 2 * cfg_model.retry_gap_ms + 2);
      else if (pick < 90) clock_ms += $urandom_range(0, 8);
      else clock_ms += $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 65) seen = clock_ms - $urandom_range(0, win + win / 8 + 2);
      else if (pick < 75) seen = clock_ms - win + $urandom_range(0, 1);
      else if (pick < 85) seen = '0;
      else seen = $urandom;
      queue_tick(clock_ms, seen, $urandom_range(0, 99) < 88);
    end
  endtask

  task automatic wait_until_drained();
    int unsigned guard;
    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while ((pending_items.size() != 0 || start || due_results.size() != 0)
               && guard < 5000);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RETRY_GAP:   cfg_model.retry_gap_ms = val;
      REG_SEND_LIMIT:  cfg_model.send_limit = val[SENDS_W-1:0];
      REG_HOST_WINDOW: cfg_model.host_window_ms = val;
      default: ;
    endcase
  endtask

  // The block is idle here, so the registers may change; entries already
  // queued keep their send counts across the change.
  task automatic run_phase(logic [MS_W-1:0] gap, logic [SENDS_W-1:0] times,
                           logic [MS_W-1:0] window, int unsigned count);
    logic [CFG_DATA_W-1:0] times_word;
    times_word = CFG_DATA_W'($urandom);
    times_word[SENDS_W-1:0] = times;
    write_reg(REG_RETRY_GAP, gap);
    write_reg(REG_SEND_LIMIT, times_word);
    write_reg(REG_HOST_WINDOW, window);
    settings_used++;
    if ($urandom_range(0, 1)) clock_ms = $urandom;
    @(negedge clk);
    repeat (count) queue_random_item();
    wait_until_drained();
  endtask

  initial begin : stimulus
    int unsigned k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset register values.
    queue_tick(32'h1000, 32'h0FFF, 1'b1);                // empty queue
    queue_note(8'h00, 32'hDEAD_BEEF);                     // code zero is ignored
    queue_note(8'hFF, 32'hFFFF_FFFF);
    queue_note(8'h01, 32'h0000_0000);
    queue_tick(32'h1000, 32'h0000_0000, 1'b1);           // host never seen
    queue_tick(32'h1000, 32'h1000 - 3000, 1'b1);         // just outside the window
    queue_tick(32'h1000, 32'h1000 - 2999, 1'b1);         // first send
    queue_tick(32'h1000 + 199, 32'h1000 + 100, 1'b0);    // no link space
    queue_tick(32'h1000 + 199, 32'h1000 + 100, 1'b1);    // gap one short
    queue_tick(32'h1000 + 200, 32'h1000 + 200, 1'b1);    // gap exactly met
    queue_tick(32'h1000 + 400, 32'h1000 + 400, 1'b1);    // last send removes the head
    queue_tick(32'hFFFF_FFF0, 32'hFFFF_FFEB, 1'b1);
    queue_tick(32'h0000_00B7, 32'h0000_00B7, 1'b1);      // wrapped gap of 199
    queue_tick(32'h0000_00B8, 32'hFFFF_FFFF, 1'b1);      // wrapped gap of 200, seen before wrap
    for (k = 2; k <= 10; k++) queue_note(CODE_W'(k), $urandom);  // overflow drops two
    queue_tick(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
    wait_until_drained();

    run_phase(16'd0, 4'd1, 16'hFFFF, 260);
    run_phase(16'hFFFF, 4'd15, 16'hFFFF, 260);
    run_phase(16'd10, 4'd0, 16'd500, 260);
    run_phase(16'd0, 4'd15, 16'd0, 120);
    for (k = 0; k < 3; k++)
      run_phase(MS_W'($urandom_range(0, 1000)), SENDS_W'($urandom_range(1, 15)),
                MS_W'($urandom_range(100, 65535)), 240);
    run_phase(16'd200, 4'd2, 16'd3000, 200);

    wait_until_drained();
    repeat (4) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0d predicted results never arrived", due_results.size());
      mismatches += due_results.size();
    end
    $display("Checked %0d results from %0d items over %0d register settings;",
             results_seen, items_taken, settings_used);
    $display("the log sent %0d events and lost %0d to overflow.", events_sent, overflow_drops);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/eqr_pkg.sv
hw/rtl/eqr_ring.sv
hw/rtl/event_queue_retransmit.sv
hw/rtl/eqr_checker.sv
verif/tb_top.sv
